// ===== rtl/ps2kmc_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 keyboard/mouse controller package
// Item types, command codes, status bits and canned reply decode.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2kmc_pkg;

   localparam int FIFO_DEPTH_DEF = 16;
   localparam int REPLY_MAX      = 4;
   localparam int IRQ_W          = 5;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_SCAN  = 2'd2,
      OP_MOUSE = 2'd3
   } op_type;

   typedef enum logic {
      CSR_KBD_IRQ   = 1'b0,
      CSR_MOUSE_IRQ = 1'b1
   } csr_idx_type;

   localparam logic [3:0] OFS_DATA  = 4'd0;
   localparam logic [3:0] OFS_CMD   = 4'd4;
   localparam logic [3:0] OFS_LIMIT = 4'd8;

   // status bits
   localparam int ST_OBF = 0;   // output buffer full
   localparam int ST_IBF = 1;   // input buffer full
   localparam int ST_AUX = 5;   // aux (mouse) data / mouse command routing

   // reply bytes
   localparam logic [7:0] RSP_ACK    = 8'hFA;
   localparam logic [7:0] RSP_BAT_OK = 8'hAA;
   localparam logic [7:0] RSP_ID_HI  = 8'hAB;
   localparam logic [7:0] RSP_ID_LO  = 8'h83;
   localparam logic [7:0] RSP_ECHO   = 8'hEE;
   localparam logic [7:0] RSP_ZERO   = 8'h00;
   localparam logic [7:0] PKT_SYNC   = 8'h08;
   localparam logic [7:0] AUX_MARK   = 8'h80;

   // keyboard commands
   localparam logic [7:0] KBD_SET_LEDS  = 8'hED;
   localparam logic [7:0] KBD_ECHO      = 8'hEE;
   localparam logic [7:0] KBD_SCAN_SET  = 8'hF0;
   localparam logic [7:0] KBD_READ_ID   = 8'hF2;
   localparam logic [7:0] KBD_TYPEMATIC = 8'hF3;
   localparam logic [7:0] KBD_ENABLE    = 8'hF4;
   localparam logic [7:0] KBD_DISABLE   = 8'hF5;
   localparam logic [7:0] KBD_DEFAULTS  = 8'hF6;
   localparam logic [7:0] KBD_RESET     = 8'hFF;

   // mouse commands
   localparam logic [7:0] MS_SCALE_1    = 8'hE6;
   localparam logic [7:0] MS_SCALE_2    = 8'hE7;
   localparam logic [7:0] MS_RESOLUTION = 8'hE8;
   localparam logic [7:0] MS_STATUS     = 8'hE9;
   localparam logic [7:0] MS_STREAM     = 8'hEA;
   localparam logic [7:0] MS_READ_DATA  = 8'hEB;
   localparam logic [7:0] MS_WRAP_OFF   = 8'hEC;
   localparam logic [7:0] MS_WRAP_ON    = 8'hEE;
   localparam logic [7:0] MS_REMOTE     = 8'hF0;
   localparam logic [7:0] MS_READ_ID    = 8'hF2;
   localparam logic [7:0] MS_RATE       = 8'hF3;
   localparam logic [7:0] MS_ENABLE     = 8'hF4;
   localparam logic [7:0] MS_DISABLE    = 8'hF5;
   localparam logic [7:0] MS_DEFAULTS   = 8'hF6;
   localparam logic [7:0] MS_RESET      = 8'hFF;

   // controller commands
   localparam logic [7:0] CTL_READ_CFG  = 8'h20;
   localparam logic [7:0] CTL_WRITE_CFG = 8'h60;
   localparam logic [7:0] CTL_AUX_OFF   = 8'hA7;
   localparam logic [7:0] CTL_AUX_ON    = 8'hA8;
   localparam logic [7:0] CTL_AUX_TEST  = 8'hA9;
   localparam logic [7:0] CTL_SELF_TEST = 8'hAA;
   localparam logic [7:0] CTL_KBD_TEST  = 8'hAB;
   localparam logic [7:0] CTL_KBD_OFF   = 8'hAD;
   localparam logic [7:0] CTL_KBD_ON    = 8'hAE;
   localparam logic [7:0] CTL_READ_IN   = 8'hC0;
   localparam logic [7:0] CTL_READ_OUT  = 8'hD0;
   localparam logic [7:0] CTL_WRITE_OUT = 8'hD1;

   typedef struct packed {
      logic [1:0]        operation;
      logic [3:0]        offset;
      logic [7:0]        write_data;
      logic [7:0]        scancode;
      logic [2:0]        buttons;
      logic signed [7:0] delta_x;
      logic signed [7:0] delta_y;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        access_ok;
      logic [7:0]  status_now;
      logic [31:0] interrupt_lines;
      logic        dropped;
   } rsp_type;

   // canned reply for a device command; data[0] is queued first
   typedef struct packed {
      logic [2:0]                     len;
      logic [REPLY_MAX-1:0][7:0]      data;
      logic                           set_obf;
      logic                           set_ibf;
   } reply_type;

   function automatic reply_type kbd_reply(input logic [7:0] cmd);
      reply_type r;
      r = '0;
      unique case (cmd)
         KBD_SET_LEDS, KBD_SCAN_SET, KBD_TYPEMATIC: r.set_ibf = 1'b1;
         KBD_ECHO: begin
            r.len = 3'd1;
            r.data[0] = RSP_ECHO;
         end
         KBD_READ_ID: begin
            r.len = 3'd3;
            r.data[0] = RSP_ACK;
            r.data[1] = RSP_ID_HI;
            r.data[2] = RSP_ID_LO;
         end
         KBD_ENABLE, KBD_DISABLE, KBD_DEFAULTS: begin
            r.len = 3'd1;
            r.data[0] = RSP_ACK;
         end
         KBD_RESET: begin
            r.len = 3'd2;
            r.data[0] = RSP_ACK;
            r.data[1] = RSP_BAT_OK;
         end
         default: r = '0;
      endcase
      r.set_obf = (r.len != 3'd0);
      return r;
   endfunction

   function automatic reply_type mouse_reply(input logic [7:0] cmd);
      reply_type r;
      r = '0;
      unique case (cmd)
         MS_RESOLUTION, MS_RATE: r.set_ibf = 1'b1;
         MS_SCALE_1, MS_SCALE_2, MS_STREAM, MS_WRAP_OFF, MS_WRAP_ON,
         MS_REMOTE, MS_ENABLE, MS_DISABLE, MS_DEFAULTS: begin
            r.len = 3'd1;
            r.data[0] = RSP_ACK;
         end
         MS_STATUS, MS_READ_DATA: begin
            r.len = 3'd4;
            r.data[0] = RSP_ACK;
         end
         MS_READ_ID: begin
            r.len = 3'd2;
            r.data[0] = RSP_ACK;
         end
         MS_RESET: begin
            r.len = 3'd3;
            r.data[0] = RSP_ACK;
            r.data[1] = RSP_BAT_OK;
         end
         default: r = '0;
      endcase
      r.set_obf = (r.len != 3'd0);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ps2_keyboard_mouse_controller.sv =====
// ----------------------------------------------------------------------------
// PS/2 keyboard/mouse controller
// 8042-style register block with keyboard and mouse byte FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a bus read, a bus write, a scancode push or a
//   mouse packet push. Each item yields exactly one rsp_* item with the read
//   byte, access status, the new status register, the interrupt vector and a
//   drop flag. csr_* sets the interrupt bit positions, written while idle.
//   The response is registered: an item accepted at an edge shows on rsp_*
//   right after it. Throughput is one item per cycle while the receiver takes
//   each response; the decode, the FIFO room check and the up-to-four-slot
//   FIFO write sit between the request handshake and the response register.
//   If the receiver stalls, the response holds and req_ready stays high only
//   while the held response is taken in the same cycle.
//   Reset empties both FIFOs, clears status, sets both enables and puts the
//   interrupt lines at bits 1 (keyboard) and 12 (mouse). FIFO contents are
//   not cleared; only written slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_keyboard_mouse_controller #(
   parameter int FIFO_DEPTH = ps2kmc_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire ps2kmc_pkg::req_type        req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output ps2kmc_pkg::rsp_type             rsp_data,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [ps2kmc_pkg::IRQ_W-1:0] csr_wdata
);

   import ps2kmc_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W = PTR_W + 1;

   // state
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [7:0]            status_ff, status_in;
   logic                  kbd_en_ff, kbd_en_in;
   logic                  mouse_en_ff, mouse_en_in;
   logic [IRQ_W-1:0]      kbd_irq_ff, mouse_irq_ff;
   logic [PTR_W-1:0]      kbd_head_ff, kbd_head_in;
   logic [PTR_W-1:0]      mouse_head_ff, mouse_head_in;
   logic [CNT_W-1:0]      kbd_count_ff, kbd_count_in;
   logic [CNT_W-1:0]      mouse_count_ff, mouse_count_in;
   logic [7:0]            kbd_mem_ff   [FIFO_DEPTH];
   logic [7:0]            mouse_mem_ff [FIFO_DEPTH];

   // per-item decode
   logic                  accept;
   reply_type             kbd_rep, mouse_rep;
   logic [2:0]            kbd_req_len, mouse_req_len;
   logic [REPLY_MAX-1:0][7:0] kbd_bytes, mouse_bytes;
   logic                  kbd_fit, mouse_fit;
   logic [2:0]            kbd_push_len, mouse_push_len;
   logic                  kbd_pop, mouse_pop;
   logic [7:0]            rdata;
   logic                  ok;
   logic [PTR_W-1:0]      kbd_pos   [REPLY_MAX];
   logic [PTR_W-1:0]      mouse_pos [REPLY_MAX];

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign kbd_rep   = kbd_reply(req_data.write_data);
   assign mouse_rep = mouse_reply(req_data.write_data);

   // operation decode: what to pop, what to queue, status and enables
   always_comb begin
      kbd_req_len   = 3'd0;
      mouse_req_len = 3'd0;
      kbd_bytes     = '0;
      mouse_bytes   = '0;
      kbd_pop       = 1'b0;
      mouse_pop     = 1'b0;
      rdata         = 8'd0;
      ok            = 1'b0;
      status_in     = status_ff;
      kbd_en_in     = kbd_en_ff;
      mouse_en_in   = mouse_en_ff;
      unique case (op_type'(req_data.operation))
         OP_READ: begin
            if (req_data.offset < OFS_LIMIT) begin
               ok = 1'b1;
               if (req_data.offset == OFS_DATA) begin
                  if (kbd_count_ff != '0) begin
                     rdata = kbd_mem_ff[kbd_head_ff];
                     kbd_pop = 1'b1;
                     status_in[ST_OBF] = 1'b0;
                  end else if (mouse_count_ff != '0) begin
                     rdata = mouse_mem_ff[mouse_head_ff] | AUX_MARK;
                     mouse_pop = 1'b1;
                     status_in[ST_OBF] = 1'b0;
                  end
               end else if (req_data.offset == OFS_CMD) begin
                  rdata = status_ff;
               end
            end
         end
         OP_WRITE: begin
            if (req_data.offset < OFS_LIMIT) begin
               ok = 1'b1;
               if (req_data.offset == OFS_DATA) begin
                  if (status_ff[ST_AUX]) begin
                     mouse_req_len = mouse_rep.len;
                     mouse_bytes   = mouse_rep.data;
                     status_in[ST_OBF] = status_ff[ST_OBF] | mouse_rep.set_obf;
                     status_in[ST_IBF] = status_ff[ST_IBF] | mouse_rep.set_ibf;
                  end else begin
                     kbd_req_len = kbd_rep.len;
                     kbd_bytes   = kbd_rep.data;
                     status_in[ST_OBF] = status_ff[ST_OBF] | kbd_rep.set_obf;
                     status_in[ST_IBF] = status_ff[ST_IBF] | kbd_rep.set_ibf;
                  end
               end else if (req_data.offset == OFS_CMD) begin
                  unique case (req_data.write_data)
                     CTL_READ_CFG, CTL_AUX_TEST, CTL_SELF_TEST, CTL_KBD_TEST,
                     CTL_READ_IN, CTL_READ_OUT: status_in[ST_OBF] = 1'b1;
                     CTL_WRITE_CFG, CTL_WRITE_OUT: status_in[ST_IBF] = 1'b1;
                     CTL_AUX_OFF: mouse_en_in = 1'b0;
                     CTL_AUX_ON:  mouse_en_in = 1'b1;
                     CTL_KBD_OFF: kbd_en_in = 1'b0;
                     CTL_KBD_ON:  kbd_en_in = 1'b1;
                     default: ;
                  endcase
               end
            end
         end
         OP_SCAN: begin
            if (kbd_en_ff) begin
               kbd_req_len  = 3'd1;
               kbd_bytes[0] = req_data.scancode;
               status_in[ST_OBF] = 1'b1;
               status_in[ST_AUX] = 1'b0;
            end
         end
         OP_MOUSE: begin
            if (mouse_en_ff) begin
               mouse_req_len  = 3'd3;
               mouse_bytes[0] = PKT_SYNC | {5'd0, req_data.buttons};
               mouse_bytes[1] = req_data.delta_x;
               mouse_bytes[2] = req_data.delta_y;
               status_in[ST_OBF] = 1'b1;
               status_in[ST_AUX] = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // room check: a reply goes in whole or not at all
   assign kbd_fit = (CNT_W + 1)'(kbd_count_ff) + (CNT_W + 1)'(kbd_req_len)
                    <= (CNT_W + 1)'(FIFO_DEPTH);
   assign mouse_fit = (CNT_W + 1)'(mouse_count_ff) + (CNT_W + 1)'(mouse_req_len)
                      <= (CNT_W + 1)'(FIFO_DEPTH);
   assign kbd_push_len   = kbd_fit   ? kbd_req_len   : 3'd0;
   assign mouse_push_len = mouse_fit ? mouse_req_len : 3'd0;

   // write slots: for every slot written, head + count + i stays below twice the depth
   always_comb begin
      logic [SUM_W-1:0] ksum, msum;
      for (int i = 0; i < REPLY_MAX; i++) begin
         ksum = SUM_W'(kbd_head_ff) + SUM_W'(kbd_count_ff) + SUM_W'(i);
         msum = SUM_W'(mouse_head_ff) + SUM_W'(mouse_count_ff) + SUM_W'(i);
         if (ksum >= SUM_W'(FIFO_DEPTH)) ksum = ksum - SUM_W'(FIFO_DEPTH);
         if (msum >= SUM_W'(FIFO_DEPTH)) msum = msum - SUM_W'(FIFO_DEPTH);
         kbd_pos[i]   = ksum[PTR_W-1:0];
         mouse_pos[i] = msum[PTR_W-1:0];
      end
   end

   always_comb begin
      kbd_head_in = kbd_head_ff;
      if (kbd_pop) begin
         kbd_head_in = (kbd_head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                       : kbd_head_ff + 1'b1;
      end
      mouse_head_in = mouse_head_ff;
      if (mouse_pop) begin
         mouse_head_in = (mouse_head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                         : mouse_head_ff + 1'b1;
      end
      kbd_count_in   = kbd_count_ff - CNT_W'(kbd_pop) + CNT_W'(kbd_push_len);
      mouse_count_in = mouse_count_ff - CNT_W'(mouse_pop) + CNT_W'(mouse_push_len);
   end

   always_comb begin
      rsp_data_in.read_data       = rdata;
      rsp_data_in.access_ok       = ok;
      rsp_data_in.status_now      = status_in;
      rsp_data_in.interrupt_lines =
         ((kbd_count_in != '0) ? (32'd1 << kbd_irq_ff) : 32'd0) |
         ((mouse_count_in != '0) ? (32'd1 << mouse_irq_ff) : 32'd0);
      rsp_data_in.dropped = (kbd_req_len != 3'd0 && !kbd_fit) ||
                            (mouse_req_len != 3'd0 && !mouse_fit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         status_ff      <= '0;
         kbd_en_ff      <= 1'b1;
         mouse_en_ff    <= 1'b1;
         kbd_head_ff    <= '0;
         kbd_count_ff   <= '0;
         mouse_head_ff  <= '0;
         mouse_count_ff <= '0;
      end else begin
         if (accept) begin
            rsp_valid_ff   <= 1'b1;
            status_ff      <= status_in;
            kbd_en_ff      <= kbd_en_in;
            mouse_en_ff    <= mouse_en_in;
            kbd_head_ff    <= kbd_head_in;
            kbd_count_ff   <= kbd_count_in;
            mouse_head_ff  <= mouse_head_in;
            mouse_count_ff <= mouse_count_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kbd_irq_ff   <= IRQ_W'(1);
         mouse_irq_ff <= IRQ_W'(12);
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_KBD_IRQ:   kbd_irq_ff   <= csr_wdata;
            CSR_MOUSE_IRQ: mouse_irq_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < REPLY_MAX; i++) begin
         if (accept && 3'(i) < kbd_push_len) begin
            kbd_mem_ff[kbd_pos[i]] <= kbd_bytes[i];
         end
         if (accept && 3'(i) < mouse_push_len) begin
            mouse_mem_ff[mouse_pos[i]] <= mouse_bytes[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ps2kmc_checker.sv =====
// ----------------------------------------------------------------------------
// PS/2 keyboard/mouse controller port checker
// Watches the top level's ports and flags response behavior that is wrong.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2kmc_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire ps2kmc_pkg::rsp_type rsp_data
);

   import ps2kmc_pkg::*;

   // no response may come out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // every drop comes with output-full set
   a_drop_obf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |-> rsp_data.status_now[ST_OBF])
      else $error("drop without output-full status");

   // at most the two FIFO interrupt bits are set
   a_irq_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(rsp_data.interrupt_lines) <= 2)
      else $error("more than two interrupt bits set");

   // only an accepted bus access returns data
   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_data != 8'd0 |-> rsp_data.access_ok)
      else $error("read data without bus access");

endmodule

bind ps2_keyboard_mouse_controller ps2kmc_checker u_checker (.*);

`default_nettype wire
